// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/pcs_pkg.sv -----
`default_nettype none
package pcs_pkg;

   localparam int NUM_CHANNELS = 2;
   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int OUT_CH = 2;

   typedef enum logic [2:0] {
      ACT_TICK     = 3'd0,
      ACT_ARM      = 3'd1,
      ACT_DISARM   = 3'd2,
      ACT_LIFTOFF  = 3'd3,
      ACT_BURNOUT  = 3'd4,
      ACT_APOGEE   = 3'd5,
      ACT_LANDING  = 3'd6,
      ACT_TESTFIRE = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      TY_DISABLED = 3'd0,
      TY_DROGUE   = 3'd1,
      TY_MAIN     = 3'd2,
      TY_AIRSTART = 3'd3,
      TY_BURNOUT  = 3'd4
   } chan_kind_type;

   localparam logic [2:0] R_TYPES   = 3'd0;
   localparam logic [2:0] R_DELAY   = 3'd1;
   localparam logic [2:0] R_MAINALT = 3'd2;
   localparam logic [2:0] R_BURNNUM = 3'd3;
   localparam logic [2:0] R_AS_ALT  = 3'd4;
   localparam logic [2:0] R_AS_ANG  = 3'd5;
   localparam logic [2:0] R_AS_VEL  = 3'd6;
   localparam logic [2:0] R_PULSE   = 3'd7;

   typedef struct packed {
      logic        cont;
      logic        firing;
      logic [31:0] fire_start;
      logic        pending;
      logic [31:0] delay_start;
      logic        main_trig;
   } chan_state_type;

   typedef struct packed {
      action_type         action;
      logic [31:0]        now_ms;
      logic               cont_bit;
      logic signed [20:0] altitude_m;
      logic signed [12:0] vertical_velocity;
      logic [8:0]         pitch_abs;
      logic [8:0]         yaw_abs;
      logic [7:0]         burnout_index;
      logic               test_sel;
      logic               live;
      logic               armed_old;
      logic               apogee_seen;
   } chan_ctx_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  delay_s;
      logic [15:0] main_alt;
      logic [7:0]  burn_num;
      logic [15:0] as_alt;
      logic [7:0]  as_ang;
      logic [15:0] as_vel;
      logic [15:0] pulse_ms;
   } chan_cfg_type;

   function automatic logic [15:0] chan_field(logic [31:0] r, logic [CH_W-1:0] ch,
                                             int unsigned w);
      logic [63:0] x;
      x = (64'(r) >> (w * 32'(ch))) & ((64'd1 << w) - 64'd1);
      return x[15:0];
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pcs_chan_unit.sv -----
`default_nettype none
// Shared per-channel update, used once per channel per item.
module pcs_chan_unit (
   input  pcs_pkg::chan_state_type st_i,
   input  pcs_pkg::chan_ctx_type   ctx_i,
   input  pcs_pkg::chan_cfg_type   cfg_i,
   output pcs_pkg::chan_state_type st_o,
   output logic                    fired_o,
   output logic                    lost_o
);
   logic [31:0] delay_el;
   logic [31:0] fire_el;
   logic [17:0] delay_lim;
   logic        as_ok;
   logic        burn_match;
   pcs_pkg::chan_state_type s;

   assign delay_lim = 18'(cfg_i.delay_s) * 18'd1000;
   assign burn_match = (cfg_i.burn_num == ctx_i.burnout_index);
   assign as_ok = ($signed({ctx_i.altitude_m[20], ctx_i.altitude_m})
          >= $signed({6'b0, cfg_i.as_alt}))
      && ($signed({{4{ctx_i.vertical_velocity[12]}}, ctx_i.vertical_velocity})
          >= $signed({1'b0, cfg_i.as_vel}))
      && (ctx_i.pitch_abs < {1'b0, cfg_i.as_ang})
      && (ctx_i.yaw_abs < {1'b0, cfg_i.as_ang});

   always_comb begin
      s = st_i;
      fired_o = 1'b0;
      lost_o = 1'b0;
      delay_el = ctx_i.now_ms - st_i.delay_start;
      fire_el = 32'd0;
      case (ctx_i.action)
         pcs_pkg::ACT_DISARM, pcs_pkg::ACT_LANDING: begin
            s.firing = 1'b0;
            s.fire_start = 32'd0;
         end
         pcs_pkg::ACT_BURNOUT: begin
            if (ctx_i.live && burn_match) begin
               if (cfg_i.kind == pcs_pkg::TY_BURNOUT ||
                   (cfg_i.kind == pcs_pkg::TY_AIRSTART && as_ok)) begin
                  s.pending = 1'b1;
                  s.delay_start = ctx_i.now_ms;
               end
            end
         end
         pcs_pkg::ACT_APOGEE: begin
            if (ctx_i.live && cfg_i.kind == pcs_pkg::TY_DROGUE) begin
               s.pending = 1'b1;
               s.delay_start = ctx_i.now_ms;
            end
         end
         pcs_pkg::ACT_TESTFIRE: begin
            if (ctx_i.test_sel && !ctx_i.armed_old) begin
               s.firing = 1'b1;
               s.fire_start = ctx_i.now_ms;
               s.pending = 1'b0;
               fired_o = 1'b1;
            end
         end
         pcs_pkg::ACT_TICK: begin
            if (st_i.cont && !ctx_i.cont_bit) begin
               s.firing = 1'b0;
               s.fire_start = 32'd0;
               lost_o = 1'b1;
            end
            s.cont = ctx_i.cont_bit;
            if (ctx_i.live) begin
               if (s.pending && delay_el > {14'd0, delay_lim}) begin
                  s.firing = 1'b1;
                  s.fire_start = ctx_i.now_ms;
                  s.pending = 1'b0;
                  fired_o = 1'b1;
               end
               fire_el = ctx_i.now_ms - s.fire_start;
               if (s.firing && fire_el > {16'd0, cfg_i.pulse_ms}) begin
                  s.firing = 1'b0;
                  s.fire_start = 32'd0;
               end
               if (ctx_i.apogee_seen && cfg_i.kind == pcs_pkg::TY_MAIN && !s.firing &&
                   !s.main_trig &&
                   $signed({ctx_i.altitude_m[20], ctx_i.altitude_m})
                      <= $signed({6'b0, cfg_i.main_alt})) begin
                  s.pending = 1'b1;
                  s.delay_start = ctx_i.now_ms;
                  s.main_trig = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      st_o = s;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/pyro_channel_sequencer.sv -----
`default_nettype none
// Channel | Direction | Contents
// req     | in        | tuser action, tdata item fields
// rsp     | out       | tdata result fields
// csr     | in        | register write, index and data
// An item passes in order through accept, each channel in turn through
// the shared channel unit, then the result register load.
// Reset is synchronous and resets control, channel and config state.
// A stalled result holds the block in its final state; req_tready is low
// from accept until the result is loaded.
`include "assert_macros.svh"
module pyro_channel_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms, continuity_bits, altitude_m, vertical_velocity, pitch_deg,
   // yaw_deg, burnout_index, test_channel
   input  logic [95:0] req_tdata,
   input  logic [2:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fet_drive, continuity_now, fired_mask, continuity_lost_mask,
   // all_configured_continuous, is_armed
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int N = pcs_pkg::NUM_CHANNELS;
   localparam int CW = pcs_pkg::CH_W;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_type;

   state_type state_ff;
   logic [CW-1:0] ch_ff;
   logic [5:0]  types_ff;
   logic [15:0] delay_ff, burnnum_ff, asang_ff, pulse_ff;
   logic [31:0] mainalt_ff, asalt_ff, asvel_ff;
   logic armed_ff, liftoff_ff, apogee_ff;
   pcs_pkg::chan_state_type chs_ff [N];
   pcs_pkg::chan_ctx_type ctx_ff, ctx_in;
   logic [N-1:0] fired_ff, lost_ff;
   logic rsp_valid_ff;
   logic [15:0] rsp_data_ff, rsp_in;
   logic req_tdata_sel_ff;

   pcs_pkg::chan_cfg_type ccfg;
   pcs_pkg::chan_state_type st_new;
   logic fired_bit, lost_bit;
   logic [8:0] pitch_raw, yaw_raw;
   logic accept, csr_hit;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign csr_hit = csr_we;

   assign pitch_raw = req_tdata[76:68];
   assign yaw_raw = req_tdata[85:77];

   always_comb begin
      ctx_in.action = pcs_pkg::action_type'(req_tuser);
      ctx_in.now_ms = req_tdata[31:0];
      ctx_in.cont_bit = req_tdata[32];
      ctx_in.altitude_m = req_tdata[54:34];
      ctx_in.vertical_velocity = req_tdata[67:55];
      ctx_in.pitch_abs = pitch_raw[8] ? 9'(-pitch_raw) : pitch_raw;
      ctx_in.yaw_abs = yaw_raw[8] ? 9'(-yaw_raw) : yaw_raw;
      ctx_in.burnout_index = req_tdata[93:86];
      ctx_in.test_sel = (CW'(req_tdata[94]) == '0);
      ctx_in.live = armed_ff && liftoff_ff;
      ctx_in.armed_old = armed_ff;
      ctx_in.apogee_seen = apogee_ff;
   end

   always_comb begin
      ccfg.kind = 3'(pcs_pkg::chan_field(32'(types_ff), ch_ff, 3));
      if (ccfg.kind > pcs_pkg::TY_BURNOUT) ccfg.kind = pcs_pkg::TY_DISABLED;
      ccfg.delay_s = 8'(pcs_pkg::chan_field(32'(delay_ff), ch_ff, 8));
      ccfg.main_alt = pcs_pkg::chan_field(mainalt_ff, ch_ff, 16);
      ccfg.burn_num = 8'(pcs_pkg::chan_field(32'(burnnum_ff), ch_ff, 8));
      ccfg.as_alt = pcs_pkg::chan_field(asalt_ff, ch_ff, 16);
      ccfg.as_ang = 8'(pcs_pkg::chan_field(32'(asang_ff), ch_ff, 8));
      ccfg.as_vel = pcs_pkg::chan_field(asvel_ff, ch_ff, 16);
      ccfg.pulse_ms = pulse_ff;
   end

   pcs_pkg::chan_ctx_type uctx;
   always_comb begin
      uctx = ctx_ff;
      uctx.cont_bit = ctx_ff.cont_bit;
   end

   pcs_chan_unit u_chan (
      .st_i    (chs_ff[ch_ff]),
      .ctx_i   (uctx),
      .cfg_i   (ccfg),
      .st_o    (st_new),
      .fired_o (fired_bit),
      .lost_o  (lost_bit)
   );

   logic [N-1:0] cont_req_ff;
   logic [1:0] fet_o, cont_o, fired_o, lost_o;
   logic allc;
   logic [2:0] k;

   always_comb begin
      fet_o = '0;
      cont_o = '0;
      fired_o = '0;
      lost_o = '0;
      allc = 1'b1;
      for (int i = 0; i < pcs_pkg::OUT_CH; i++) begin
         if (i < N) begin
            fet_o[i] = chs_ff[i].firing;
            cont_o[i] = chs_ff[i].cont;
            fired_o[i] = fired_ff[i];
            lost_o[i] = lost_ff[i];
         end
      end
      for (int i = 0; i < N; i++) begin
         k = 3'(pcs_pkg::chan_field(32'(types_ff), CW'(i), 3));
         if (k != pcs_pkg::TY_DISABLED && k <= pcs_pkg::TY_BURNOUT && !chs_ff[i].cont)
            allc = 1'b0;
      end
      rsp_in = {6'd0, armed_ff, allc, lost_o, fired_o, cont_o, fet_o};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff <= '0;
         types_ff <= '0;
         delay_ff <= '0;
         mainalt_ff <= '0;
         burnnum_ff <= '0;
         asalt_ff <= '0;
         asang_ff <= '0;
         asvel_ff <= '0;
         pulse_ff <= 16'd1000;
         armed_ff <= 1'b0;
         liftoff_ff <= 1'b0;
         apogee_ff <= 1'b0;
         for (int i = 0; i < N; i++) chs_ff[i] <= '0;
         fired_ff <= '0;
         lost_ff <= '0;
         cont_req_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         if (csr_hit) begin
            unique case (csr_index)
               pcs_pkg::R_TYPES:   types_ff <= csr_wdata[5:0];
               pcs_pkg::R_DELAY:   delay_ff <= csr_wdata[15:0];
               pcs_pkg::R_MAINALT: mainalt_ff <= csr_wdata;
               pcs_pkg::R_BURNNUM: burnnum_ff <= csr_wdata[15:0];
               pcs_pkg::R_AS_ALT:  asalt_ff <= csr_wdata;
               pcs_pkg::R_AS_ANG:  asang_ff <= csr_wdata[15:0];
               pcs_pkg::R_AS_VEL:  asvel_ff <= csr_wdata;
               pcs_pkg::R_PULSE:   pulse_ff <= csr_wdata[15:0];
               default: ;
            endcase
            armed_ff <= 1'b0;
            for (int i = 0; i < N; i++) begin
               chs_ff[i].firing <= 1'b0;
               chs_ff[i].fire_start <= 32'd0;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ctx_ff <= ctx_in;
                  cont_req_ff <= N'(req_tdata[33:32]);
                  ch_ff <= '0;
                  fired_ff <= '0;
                  lost_ff <= '0;
                  case (ctx_in.action)
                     pcs_pkg::ACT_ARM: armed_ff <= 1'b1;
                     pcs_pkg::ACT_DISARM, pcs_pkg::ACT_LANDING: armed_ff <= 1'b0;
                     pcs_pkg::ACT_LIFTOFF: liftoff_ff <= 1'b1;
                     pcs_pkg::ACT_APOGEE: if (ctx_in.live) apogee_ff <= 1'b1;
                     default: ;
                  endcase
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               chs_ff[ch_ff] <= st_new;
               fired_ff[ch_ff] <= fired_bit;
               lost_ff[ch_ff] <= lost_bit;
               if (ch_ff == CW'(N - 1)) begin
                  state_ff <= S_DONE;
               end else begin
                  ch_ff <= ch_ff + 1'b1;
                  ctx_ff.cont_bit <= cont_req_ff[ch_ff + 1'b1];
                  ctx_ff.test_sel <= (CW'(req_tdata_sel_ff) == ch_ff + 1'b1);
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_tdata_sel_ff <= req_tdata[94];
   end

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `ASSERT_NOW(a_fired_drives, clock, reset, rsp_tvalid,
      (rsp_tdata[5:4] & ~rsp_tdata[1:0]) == 2'b00)
   `ASSERT_NOW(a_lost_not_cont, clock, reset, rsp_tvalid,
      (rsp_tdata[7:6] & rsp_tdata[3:2]) == 2'b00)
endmodule
`default_nettype wire
